// File: rtl/drfir_pkg.sv
// Package for the decimating complex RRC FIR: tap tables, config port
// types and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drfir_pkg;

  // Fixed filter geometry
  localparam int TAP_COUNT    = 31;
  localparam int HALF_TAPS    = 16;
  localparam int TABLE_BITS   = 18;  // table taps are Q1.17
  localparam int TAP_IDX_W    = 5;
  localparam int QUEUE_DEPTH  = 2;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_DECIMATION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_SET  = 2'd1;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  // Taps 0..15 of each set, Q1.17; tap k above 15 mirrors tap 30-k
  localparam logic signed [TABLE_BITS-1:0] RRC_HALF [4][HALF_TAPS] = '{
    '{-18'sd1149, -18'sd1645, -18'sd2000, -18'sd2107, -18'sd1869, -18'sd1215,
      -18'sd111, 18'sd1431, 18'sd3346, 18'sd5522, 18'sd7808, 18'sd10026,
      18'sd11994, 18'sd13541, 18'sd14529, 18'sd14869},
    '{18'sd542, 18'sd93, -18'sd608, -18'sd1438, -18'sd2191, -18'sd2617,
      -18'sd2460, -18'sd1521, 18'sd294, 18'sd2938, 18'sd6210, 18'sd9773,
      18'sd13204, 18'sd16060, 18'sd17951, 18'sd18613},
    '{18'sd272, -18'sd32, -18'sd405, -18'sd64, 18'sd610, 18'sd396,
      -18'sd592, -18'sd517, 18'sd1130, 18'sd1435, -18'sd2271, -18'sd6412,
      -18'sd2096, 18'sd14925, 18'sd36190, 18'sd45938},
    '{18'sd130, -18'sd282, -18'sd64, 18'sd341, -18'sd196, -18'sd423,
      18'sd604, 18'sd496, -18'sd936, 18'sd280, 18'sd2132, -18'sd2847,
      -18'sd8105, 18'sd6321, 18'sd39295, 18'sd57582}
  };

  // Symmetric tap lookup
  function automatic logic signed [TABLE_BITS-1:0] rrc_tap(
    input logic [1:0]           set,
    input logic [TAP_IDX_W-1:0] k
  );
    logic [TAP_IDX_W-1:0] mirror;
    mirror = (k < TAP_IDX_W'(HALF_TAPS)) ? k : (TAP_IDX_W'(TAP_COUNT - 1) - k);
    return RRC_HALF[set][mirror[3:0]];
  endfunction

endpackage

`default_nettype wire

// File: rtl/drfir_front.sv
// Front end: takes input samples, tracks the decimation phase and tags each
// request that produces an output. Depends on drfir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drfir_front #(
  parameter int SAMPLE_BITS    = 16,
  parameter int MAX_DECIMATION = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  drfir_pkg::cfg_wr_t          cfg_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0] sample_i_i,
  input  wire  signed [SAMPLE_BITS-1:0] sample_q_i,
  // queue write side
  output logic                        push_o,
  output logic [2*SAMPLE_BITS:0]      push_data_o,
  input  wire                         q_full_i
);
  import drfir_pkg::*;

  localparam int PH_W  = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
  localparam int DEC_W = $clog2(MAX_DECIMATION + 1);

  logic [CFG_DATA_W-1:0] decim_q;
  logic [DEC_W-1:0]      dec_eff;
  logic [PH_W-1:0]       phase_q, phase_d;
  logic [PH_W:0]         phase_inc;
  logic                  emit;

  // Decimation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decim_q <= CFG_DATA_W'(1);
    end else if (cfg_i.we && cfg_i.index == REG_DECIMATION) begin
      decim_q <= cfg_i.data;
    end
  end

  // Zero acts as one, large values clip to the maximum
  always_comb begin
    if (decim_q == '0) begin
      dec_eff = DEC_W'(1);
    end else if (int'(decim_q) > MAX_DECIMATION) begin
      dec_eff = DEC_W'(MAX_DECIMATION);
    end else begin
      dec_eff = DEC_W'(decim_q);
    end
  end

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign emit        = (phase_q == '0);
  assign push_data_o = {emit, sample_i_i, sample_q_i};

  // Phase advance; wraps at or beyond the current decimation
  always_comb begin
    phase_inc = {1'b0, phase_q} + (PH_W + 1)'(1);
    if (int'(phase_inc) >= int'(dec_eff)) begin
      phase_d = '0;
    end else begin
      phase_d = phase_inc[PH_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/drfir_queue.sv
// Small FIFO between front and back ends.
// Depends on drfir_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module drfir_queue #(
  parameter int WIDTH = 33
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);
  import drfir_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/drfir_back.sv
// Back end: delay lines, serial multiply-accumulate over the taps, rounding,
// saturation and the output register. Depends on drfir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drfir_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 18
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  drfir_pkg::cfg_wr_t            cfg_i,
  // queue read side
  input  wire                           q_valid_i,
  input  wire  [2*SAMPLE_BITS:0]        q_head_i,
  output logic                          q_pop_o,
  // result channel
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_i_o,
  output logic signed [SAMPLE_BITS-1:0] out_q_o
);
  import drfir_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT);
  localparam int CNT_W  = $clog2(TAP_COUNT + 1);
  localparam int IDX_W  = $clog2(TAP_COUNT);
  localparam int RSH    = COEFF_BITS - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd1 <<< (SAMPLE_BITS - 1));
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (RSH - 1));

  logic [1:0]  state_q;
  logic [CNT_W-1:0] k_q;
  logic [1:0]  coeff_set_q;

  logic signed [SAMPLE_BITS-1:0] hist_i_q [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0] hist_q_q [TAP_COUNT];

  logic                          head_emit;
  logic signed [SAMPLE_BITS-1:0] head_si, head_sq;

  logic [IDX_W-1:0]              idx;
  logic signed [TABLE_BITS-1:0]  tap_tbl;
  logic signed [COEFF_BITS-1:0]  tap_c;
  logic signed [PROD_W-1:0]      prod_i_q, prod_q_q;
  logic signed [ACC_W-1:0]       acc_i_q, acc_q_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_i_q, out_q_q;
  logic                          out_free, res_load, shift_en;

  assign {head_emit, head_si, head_sq} = q_head_i;

  // Tap set register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_set_q <= 2'd0;
    end else if (cfg_i.we && cfg_i.index == REG_COEFF_SET) begin
      coeff_set_q <= cfg_i.data[1:0];
    end
  end

  // Tap lookup, rescaled from Q1.17 to the coefficient width
  assign idx     = (k_q < CNT_W'(TAP_COUNT)) ? k_q[IDX_W-1:0] : '0;
  assign tap_tbl = rrc_tap(coeff_set_q, TAP_IDX_W'(idx));

  generate
    if (COEFF_BITS >= TABLE_BITS) begin : g_tap_up
      assign tap_c = COEFF_BITS'(tap_tbl) <<< (COEFF_BITS - TABLE_BITS);
    end else begin : g_tap_down
      localparam int DSH = TABLE_BITS - COEFF_BITS;
      logic signed [TABLE_BITS:0] tap_rnd;
      assign tap_rnd = (TABLE_BITS + 1)'(tap_tbl) + ((TABLE_BITS + 1)'(1) <<< (DSH - 1));
      assign tap_c   = COEFF_BITS'(tap_rnd >>> DSH);
    end
  endgenerate

  // Round half up, then clip to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] finish(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] r;
    r = (acc + HALF) >>> RSH;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign res_load = (state_q == ST_FIN) && out_free;
  assign shift_en = ((state_q == ST_IDLE) && q_valid_i && !head_emit) || res_load;
  assign q_pop_o  = shift_en;

  // Sequencer: one product per rail per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i && head_emit) begin
            state_q <= ST_MAC;
            k_q     <= '0;
          end
        end
        ST_MAC: begin
          k_q <= k_q + CNT_W'(1);
          if (k_q == CNT_W'(TAP_COUNT)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Multiply stage and accumulator; the registered product of tap k is added in the following cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (state_q == ST_MAC) begin
      if (k_q < CNT_W'(TAP_COUNT)) begin
        prod_i_q <= hist_i_q[idx] * tap_c;
        prod_q_q <= hist_q_q[idx] * tap_c;
      end
      if (k_q != '0) begin
        acc_i_q <= acc_i_q + ACC_W'(prod_i_q);
        acc_q_q <= acc_q_q + ACC_W'(prod_q_q);
      end
    end
  end

  // Delay lines, shifted once the current request is done with them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TAP_COUNT; j++) begin
        hist_i_q[j] <= '0;
        hist_q_q[j] <= '0;
      end
    end else if (shift_en) begin
      for (int j = 0; j < TAP_COUNT - 1; j++) begin
        hist_i_q[j] <= hist_i_q[j+1];
        hist_q_q[j] <= hist_q_q[j+1];
      end
      hist_i_q[TAP_COUNT-1] <= head_si;
      hist_q_q[TAP_COUNT-1] <= head_sq;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_i_q <= finish(acc_i_q);
      out_q_q <= finish(acc_q_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

  // A job in flight keeps its request at the queue head
  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> q_valid_i)
    else $error("queue head lost during a filter job");

  // Shifting only happens for a queued request
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  // Tap counter stays within the MAC sweep
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (k_q <= CNT_W'(TAP_COUNT)))
    else $error("tap counter out of range");

  // A loaded result returns the sequencer to idle
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("result load did not complete the job");

endmodule

`default_nettype wire

// File: rtl/decimating_complex_rrc_fir_unit.sv
// Top level of the decimating complex 31-tap RRC FIR.
// Depends on drfir_pkg, drfir_front, drfir_queue and drfir_back.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid_i, in_stall_o, sample_*_i    | in
//  result  | out_valid_o, out_stall_i, out_*_o     | out
//  config  | cfg_we_i, cfg_index_i, cfg_data_i     | in
//
// A request with no output is shifted in while the back end is idle, so
// such requests stream at one per cycle. A request with an output is
// issued, then one serial multiplier per rail walks the 31 taps, then the
// sums are rounded and saturated. A two-entry queue decouples input from
// the MAC. Reset clears delay lines, phase and control registers at once.
// A stalled result holds in out_*_o; input flows until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module decimating_complex_rrc_fir_unit #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEFF_BITS     = 18,
  parameter int MAX_DECIMATION = 16
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire  [drfir_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  wire  [drfir_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0]           sample_i_i,
  input  wire  signed [SAMPLE_BITS-1:0]           sample_q_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]           out_i_o,
  output logic signed [SAMPLE_BITS-1:0]           out_q_o
);
  import drfir_pkg::*;

  localparam int QW = 2 * SAMPLE_BITS + 1;

  cfg_wr_t         cfg;
  logic            push, q_full, q_valid, q_pop;
  logic [QW-1:0]   push_data, q_head;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  drfir_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .MAX_DECIMATION(MAX_DECIMATION)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i_i (sample_i_i),
    .sample_q_i (sample_q_i),
    .push_o     (push),
    .push_data_o(push_data),
    .q_full_i   (q_full)
  );

  drfir_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  drfir_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_i_o    (out_i_o),
    .out_q_o    (out_q_o)
  );

endmodule

`default_nettype wire
